// ===== rtl/imp_pkg.sv =====
// Shared constants, codes and transfer types of the isometric mouse picker.
package imp_pkg;

  localparam int PTR_W   = 12;
  localparam int COORD_W = 16;
  localparam int WORLD_W = 18;
  localparam int MAG_W   = 17;
  localparam int DIV_W   = 7;
  localparam int TILE_W  = 19;
  localparam int CODE_W  = 3;
  localparam int LIDX_W  = 12;
  localparam int FIDX_W  = 14;
  localparam int QDEPTH  = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef enum logic [CODE_W-1:0] {
    REGION_CENTRE = 3'd0,
    REGION_NW     = 3'd1,
    REGION_NE     = 3'd2,
    REGION_SW     = 3'd3,
    REGION_SE     = 3'd4
  } region_t;

  typedef enum logic [1:0] {
    REG_CELL_WIDTH  = 2'd0,
    REG_CELL_HEIGHT = 2'd1,
    REG_REFERENCE_X = 2'd2,
    REG_REFERENCE_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DIV_W-1:0]          cell_w;
    logic [DIV_W-1:0]          cell_h;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
  } imp_cfg_t;

  typedef struct packed {
    logic              mode;
    logic              neg_x;
    logic [MAG_W-1:0]  mag_x;
    logic              neg_y;
    logic [MAG_W-1:0]  mag_y;
    logic [LIDX_W-1:0] entry_index;
    logic [CODE_W-1:0] entry_code;
  } imp_job_t;

endpackage

// ===== rtl/imp_if.sv =====
// Valid/ready channel interfaces for pick/load items and tile results.
interface imp_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    mode;
  logic [imp_pkg::PTR_W-1:0]               pointer_x;
  logic [imp_pkg::PTR_W-1:0]               pointer_y;
  logic signed [imp_pkg::COORD_W-1:0]      anchor_x;
  logic signed [imp_pkg::COORD_W-1:0]      anchor_y;
  logic [imp_pkg::LIDX_W-1:0]              entry_index;
  logic [imp_pkg::CODE_W-1:0]              entry_code;

  modport source (output valid, mode, pointer_x, pointer_y, anchor_x, anchor_y,
                  entry_index, entry_code, input ready);
  modport sink (input valid, mode, pointer_x, pointer_y, anchor_x, anchor_y,
                entry_index, entry_code, output ready);
endinterface

interface imp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [imp_pkg::TILE_W-1:0] tile_x;
  logic signed [imp_pkg::TILE_W-1:0] tile_y;

  modport source (output valid, tile_x, tile_y, input ready);
  modport sink (input valid, tile_x, tile_y, output ready);
endinterface

// ===== rtl/imp_cfg.sv =====
// APB-style configuration registers with divisor zero handling.
module imp_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [imp_pkg::ADDR_W-1:0]   paddr,
  input  logic [imp_pkg::DATA_W-1:0]   pwdata,
  output logic [imp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output imp_pkg::imp_cfg_t            cfg
);

  logic [imp_pkg::DIV_W-1:0]          cell_width_r;
  logic [imp_pkg::DIV_W-1:0]          cell_height_r;
  logic signed [imp_pkg::COORD_W-1:0] reference_x_r;
  logic signed [imp_pkg::COORD_W-1:0] reference_y_r;
  logic                               wr_en;
  imp_pkg::cfg_reg_t                  sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = imp_pkg::cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= imp_pkg::DIV_W'(64);
      cell_height_r <= imp_pkg::DIV_W'(32);
      reference_x_r <= '0;
      reference_y_r <= '0;
    end else if (wr_en) begin
      case (sel)
        imp_pkg::REG_CELL_WIDTH:  cell_width_r  <= pwdata[imp_pkg::DIV_W-1:0];
        imp_pkg::REG_CELL_HEIGHT: cell_height_r <= pwdata[imp_pkg::DIV_W-1:0];
        imp_pkg::REG_REFERENCE_X: reference_x_r <= pwdata[imp_pkg::COORD_W-1:0];
        imp_pkg::REG_REFERENCE_Y: reference_y_r <= pwdata[imp_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      imp_pkg::REG_CELL_WIDTH:  prdata = imp_pkg::DATA_W'(cell_width_r);
      imp_pkg::REG_CELL_HEIGHT: prdata = imp_pkg::DATA_W'(cell_height_r);
      imp_pkg::REG_REFERENCE_X: prdata = imp_pkg::DATA_W'(reference_x_r);
      imp_pkg::REG_REFERENCE_Y: prdata = imp_pkg::DATA_W'(reference_y_r);
      default:                  prdata = '0;
    endcase
  end

  // zero divisor divides as one
  assign cfg.cell_w = (cell_width_r == '0) ? imp_pkg::DIV_W'(1) : cell_width_r;
  assign cfg.cell_h = (cell_height_r == '0) ? imp_pkg::DIV_W'(1) : cell_height_r;
  assign cfg.ref_x  = reference_x_r;
  assign cfg.ref_y  = reference_y_r;

endmodule

// ===== rtl/imp_front.sv =====
// Front end: world position, sign split and the item queue.
module imp_front (
  input  logic              clk,
  input  logic              rst_n,
  imp_in_if.sink            in_ch,
  input  imp_pkg::imp_cfg_t cfg,
  output imp_pkg::imp_job_t job,
  output logic              job_valid,
  input  logic              job_pop
);

  localparam int PW = $clog2(imp_pkg::QDEPTH);
  localparam int CW = $clog2(imp_pkg::QDEPTH + 1);

  imp_pkg::imp_job_t                  q_r [imp_pkg::QDEPTH];
  logic [PW-1:0]                      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]                      count_r;
  logic signed [imp_pkg::WORLD_W-1:0] wx, wy, ax, ay;
  imp_pkg::imp_job_t                  push_job;
  logic                               push;

  assign wx = imp_pkg::WORLD_W'({1'b0, in_ch.pointer_x}) + imp_pkg::WORLD_W'(in_ch.anchor_x)
            - imp_pkg::WORLD_W'(cfg.ref_x);
  assign wy = imp_pkg::WORLD_W'({1'b0, in_ch.pointer_y}) + imp_pkg::WORLD_W'(in_ch.anchor_y)
            - imp_pkg::WORLD_W'(cfg.ref_y);
  assign ax = wx[imp_pkg::WORLD_W-1] ? -wx : wx;
  assign ay = wy[imp_pkg::WORLD_W-1] ? -wy : wy;

  always_comb begin
    push_job.mode        = in_ch.mode;
    push_job.neg_x       = wx[imp_pkg::WORLD_W-1];
    push_job.mag_x       = ax[imp_pkg::MAG_W-1:0];
    push_job.neg_y       = wy[imp_pkg::WORLD_W-1];
    push_job.mag_y       = ay[imp_pkg::MAG_W-1:0];
    push_job.entry_index = in_ch.entry_index;
    push_job.entry_code  = in_ch.entry_code;
  end

  assign in_ch.ready = (count_r != CW'(imp_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign job_valid   = (count_r != '0);
  assign job         = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (job_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + CW'(push) - CW'(job_pop);
    end
  end

endmodule

// ===== rtl/imp_back.sv =====
// Back end: pipelined floor divider, region table lookup and result register.
module imp_back #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  imp_pkg::imp_job_t job,
  input  logic              job_valid,
  output logic              job_pop,
  input  imp_pkg::imp_cfg_t cfg,
  imp_out_if.source         out_ch
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NS = imp_pkg::MAG_W;

  typedef struct packed {
    logic [imp_pkg::DIV_W-1:0] rem;
    logic [imp_pkg::MAG_W-1:0] num;
  } lane_t;

  typedef struct packed {
    logic                       valid;
    logic                       mode;
    logic                       neg_x;
    lane_t                      lx;
    logic                       neg_y;
    lane_t                      ly;
    logic [imp_pkg::LIDX_W-1:0] lidx;
    logic [imp_pkg::CODE_W-1:0] code;
  } div_t;

  function automatic lane_t div_step(lane_t a, logic [imp_pkg::DIV_W-1:0] d);
    logic [imp_pkg::DIV_W:0] t;
    lane_t b;
    t = {a.rem, a.num[imp_pkg::MAG_W-1]};
    if (t >= {1'b0, d}) begin
      b.rem = imp_pkg::DIV_W'(t - {1'b0, d});
      b.num = {a.num[imp_pkg::MAG_W-2:0], 1'b1};
    end else begin
      b.rem = t[imp_pkg::DIV_W-1:0];
      b.num = {a.num[imp_pkg::MAG_W-2:0], 1'b0};
    end
    return b;
  endfunction

  logic                                en;
  div_t                                st_r [NS+1];

  logic                                f1_valid_r, f1_mode_r;
  logic signed [imp_pkg::WORLD_W-1:0]  cx_r, cy_r;
  logic [imp_pkg::DIV_W-1:0]           fx_r, fy_r;
  logic [imp_pkg::LIDX_W-1:0]          f1_lidx_r;
  logic [imp_pkg::CODE_W-1:0]          f1_code_r;
  logic signed [imp_pkg::WORLD_W-1:0]  cx_nxt, cy_nxt;
  logic [imp_pkg::DIV_W-1:0]           fx_nxt, fy_nxt;

  logic                                f2_valid_r, f2_mode_r, f2_hit_r;
  logic signed [imp_pkg::TILE_W-1:0]   f2_tx_r, f2_ty_r;
  logic [IW-1:0]                       f2_addr_r;
  logic [imp_pkg::CODE_W-1:0]          f2_code_r;
  logic [imp_pkg::FIDX_W-1:0]          fidx;
  logic                                f2_hit_nxt;
  logic [IW-1:0]                       f2_addr_nxt;

  logic [imp_pkg::CODE_W-1:0]          mem [TABLE_ENTRIES];
  logic [imp_pkg::CODE_W-1:0]          rd_r;
  logic                                f3_valid_r, f3_mode_r, f3_hit_r;
  logic signed [imp_pkg::TILE_W-1:0]   f3_tx_r, f3_ty_r;

  logic                                out_valid_r;
  logic signed [imp_pkg::TILE_W-1:0]   tile_x_r, tile_y_r;
  logic signed [imp_pkg::TILE_W-1:0]   tile_x_nxt, tile_y_nxt;
  logic [imp_pkg::CODE_W-1:0]          region;

  assign en      = !out_valid_r || out_ch.ready;
  assign job_pop = en && job_valid;

  // divider pipeline, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) st_r[i].valid <= 1'b0;
    end else if (en) begin
      st_r[0].valid  <= job_valid;
      st_r[0].mode   <= job.mode;
      st_r[0].neg_x  <= job.neg_x;
      st_r[0].lx.rem <= '0;
      st_r[0].lx.num <= job.mag_x;
      st_r[0].neg_y  <= job.neg_y;
      st_r[0].ly.rem <= '0;
      st_r[0].ly.num <= job.mag_y;
      st_r[0].lidx   <= job.entry_index;
      st_r[0].code   <= job.entry_code;
      for (int i = 0; i < NS; i++) begin
        st_r[i+1].valid <= st_r[i].valid;
        st_r[i+1].mode  <= st_r[i].mode;
        st_r[i+1].neg_x <= st_r[i].neg_x;
        st_r[i+1].lx    <= div_step(st_r[i].lx, cfg.cell_w);
        st_r[i+1].neg_y <= st_r[i].neg_y;
        st_r[i+1].ly    <= div_step(st_r[i].ly, cfg.cell_h);
        st_r[i+1].lidx  <= st_r[i].lidx;
        st_r[i+1].code  <= st_r[i].code;
      end
    end
  end

  // floor correction of negative dividends
  always_comb begin
    if (st_r[NS].neg_x && st_r[NS].lx.rem != '0) begin
      cx_nxt = -(imp_pkg::WORLD_W'(st_r[NS].lx.num) + 1'b1);
      fx_nxt = cfg.cell_w - st_r[NS].lx.rem;
    end else if (st_r[NS].neg_x) begin
      cx_nxt = -imp_pkg::WORLD_W'(st_r[NS].lx.num);
      fx_nxt = '0;
    end else begin
      cx_nxt = imp_pkg::WORLD_W'(st_r[NS].lx.num);
      fx_nxt = st_r[NS].lx.rem;
    end
    if (st_r[NS].neg_y && st_r[NS].ly.rem != '0) begin
      cy_nxt = -(imp_pkg::WORLD_W'(st_r[NS].ly.num) + 1'b1);
      fy_nxt = cfg.cell_h - st_r[NS].ly.rem;
    end else if (st_r[NS].neg_y) begin
      cy_nxt = -imp_pkg::WORLD_W'(st_r[NS].ly.num);
      fy_nxt = '0;
    end else begin
      cy_nxt = imp_pkg::WORLD_W'(st_r[NS].ly.num);
      fy_nxt = st_r[NS].ly.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= st_r[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_mode_r <= st_r[NS].mode;
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      fx_r      <= fx_nxt;
      fy_r      <= fy_nxt;
      f1_lidx_r <= st_r[NS].lidx;
      f1_code_r <= st_r[NS].code;
    end
  end

  // coarse walk, fine index and table address
  assign fidx = imp_pkg::FIDX_W'(fx_r) + imp_pkg::FIDX_W'(fy_r) * imp_pkg::FIDX_W'(cfg.cell_w);

  always_comb begin
    if (f1_mode_r) begin
      f2_hit_nxt  = (32'(f1_lidx_r) < TABLE_ENTRIES);
      f2_addr_nxt = IW'(f1_lidx_r);
    end else begin
      f2_hit_nxt  = (32'(fidx) < TABLE_ENTRIES);
      f2_addr_nxt = IW'(fidx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (en) begin
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_mode_r <= f1_mode_r;
      f2_hit_r  <= f2_hit_nxt;
      f2_addr_r <= f2_addr_nxt;
      f2_code_r <= f1_code_r;
      f2_tx_r   <= imp_pkg::TILE_W'(cy_r) + imp_pkg::TILE_W'(cx_r);
      f2_ty_r   <= imp_pkg::TILE_W'(cy_r) - imp_pkg::TILE_W'(cx_r);
    end
  end

  // region table
  always_ff @(posedge clk) begin
    if (en) begin
      if (f2_valid_r && f2_mode_r && f2_hit_r) mem[f2_addr_r] <= f2_code_r;
      rd_r <= mem[f2_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_valid_r <= 1'b0;
    end else if (en) begin
      f3_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_mode_r <= f2_mode_r;
      f3_hit_r  <= f2_hit_r;
      f3_tx_r   <= f2_tx_r;
      f3_ty_r   <= f2_ty_r;
    end
  end

  assign region = f3_hit_r ? rd_r : imp_pkg::CODE_W'(imp_pkg::REGION_CENTRE);

  always_comb begin
    tile_x_nxt = f3_tx_r;
    tile_y_nxt = f3_ty_r;
    case (region)
      imp_pkg::REGION_NW: tile_x_nxt = f3_tx_r - 1'b1;
      imp_pkg::REGION_NE: tile_y_nxt = f3_ty_r - 1'b1;
      imp_pkg::REGION_SW: tile_y_nxt = f3_ty_r + 1'b1;
      imp_pkg::REGION_SE: tile_x_nxt = f3_tx_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f3_valid_r && !f3_mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tile_x_r <= tile_x_nxt;
      tile_y_r <= tile_y_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.tile_x = tile_x_r;
  assign out_ch.tile_y = tile_y_r;

  a_fine_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    f1_valid_r && !f1_mode_r |-> fx_r < cfg.cell_w)
    else $error("fine x offset not below cell width");

  a_fine_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    f1_valid_r && !f1_mode_r |-> fy_r < cfg.cell_h)
    else $error("fine y offset not below cell height");

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(rd_r))
    else $error("table read data moved during stall");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("queue popped while empty");

endmodule

// ===== rtl/isometric_mouse_picker_top.sv =====
// Top level of the isometric mouse picker.
// Usage:
//   in_ch carries items: mode 0 picks the tile under a pointer, mode 1 writes one
//   region table entry (entry_index, entry_code) and yields no result.
//   out_ch returns tile_x, tile_y for each pick item, in item order.
//   Both channels transfer a transaction when valid and ready are high at a clock edge.
//   The APB port sets cell size and reference point; write it only while idle.
//   Throughput: one item per cycle while out_ch.ready stays high. Items pass through
//   the four-entry queue, a 17-stage floor divider (one quotient bit per
//   stage), the fine index multiply and the registered region table read.
//   Load items pass the same pipeline, so a pick sees every earlier table write.
//   Reset (rst_n low, synchronous) empties queue and pipeline and restores
//   cell 64 x 32 and reference 0, 0; the region table keeps no reset value and
//   must be written before it is read.
//   When out_ch.valid is high and out_ch.ready is low the whole back end holds; the
//   queue keeps accepting until its four entries are full, then in_ch.ready drops.
module isometric_mouse_picker_top #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  imp_in_if.sink                      in_ch,
  imp_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [imp_pkg::ADDR_W-1:0]  paddr,
  input  logic [imp_pkg::DATA_W-1:0]  pwdata,
  output logic [imp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  imp_pkg::imp_cfg_t cfg;
  imp_pkg::imp_job_t job;
  logic              job_valid;
  logic              job_pop;

  imp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop)
  );

  imp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );

endmodule
